### rtl/rbee_pkg.sv
// Shared types, register indexes and fixed-point constants of the radial band
// emphasis block. No dependencies; top, front, back and testbench import it.
`default_nettype none

package rbee_pkg;

  // Depth of the queues between front, back and result port
  localparam int QUEUE_DEPTH = 2;

  // Number of Taylor terms in the 2^f series
  localparam int HORNER_TERMS = 10;

  // Fixed-point constants
  localparam logic [31:0] Q30_ONE   = 32'd1073741824;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [30:0] GAIN_MAX  = 31'h7FFFFFFF;

  // Register reset values
  localparam logic [23:0] STEP_RST = 24'd65536;
  localparam logic [23:0] LOW_RST  = 24'd0;
  localparam logic [23:0] HIGH_RST = 24'd8388608;

  // Band codes
  localparam logic [1:0] BAND_BELOW  = 2'd0;
  localparam logic [1:0] BAND_INSIDE = 2'd1;
  localparam logic [1:0] BAND_ABOVE  = 2'd2;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_X_STEP = 3'd0,
    REG_Y_STEP = 3'd1,
    REG_Z_STEP = 3'd2,
    REG_LOW    = 3'd3,
    REG_HIGH   = 3'd4,
    REG_LINEAR = 3'd5,
    REG_QUAD   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic        [23:0] x_freq_step;
    logic        [23:0] y_freq_step;
    logic        [23:0] z_freq_step;
    logic        [23:0] low_cutoff;
    logic        [23:0] high_cutoff;
    logic signed [31:0] linear_coef;
    logic signed [31:0] quad_coef;
  } cfg_t;

  typedef struct packed {
    logic        [7:0]  idx_x;
    logic signed [7:0]  idx_y;
    logic signed [7:0]  idx_z;
    logic signed [31:0] re_in;
    logic signed [31:0] im_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] re_out;
    logic signed [31:0] im_out;
    logic        [1:0]  band;
    logic               saturated;
  } out_item_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic        [1:0]  band;
    logic        [23:0] r;
    logic        [23:0] rr;
  } mid_item_t;

  // floor(2^32 / k) for the Horner divisors
  function automatic logic [32:0] recip_q32(input int unsigned k);
    logic [32:0] m;
    begin
      case (k)
        1:       m = 33'h1_0000_0000;
        2:       m = 33'd2147483648;
        3:       m = 33'd1431655765;
        4:       m = 33'd1073741824;
        5:       m = 33'd858993459;
        6:       m = 33'd715827882;
        7:       m = 33'd613566756;
        8:       m = 33'd536870912;
        9:       m = 33'd477218588;
        10:      m = 33'd429496729;
        default: m = 33'd0;
      endcase
      return m;
    end
  endfunction

endpackage

`default_nettype wire

### rtl/radial_band_exp_emphasis.sv
// Radial band exp emphasis of Fourier coefficients.
// Input side is a handshake: push an item while full is low; one item per cycle
// is taken. The front scales the frequency indices, forms the squared radius,
// picks the band (below, inside, above the cutoffs) and takes the square root
// in a 24-stage bit-per-stage pipeline. A two-entry queue hands the item to
// the back, which forms A*r + B*r^2, evaluates exp() with a three-stage-per-
// term Horner series and scales the real and imaginary parts with saturation.
// Result side is a queue: the oldest result sits on result while empty is
// low and leaves on pop. Throughput is one item per cycle while nothing
// stalls, set by the fully pipelined front and back. When the receiver
// stops popping, the back stalls once its output queue fills, then the
// front once the middle queue fills, and full rises. Reset (rst, synchronous)
// empties all queues and pipelines and loads the register defaults. Registers
// are written through cfg_wr, cfg_addr and cfg_data and must only change
// while no item is in flight.
// Uses rbee_pkg, rbee_fifo, rbee_front and rbee_back.
`default_nettype none

module radial_band_exp_emphasis import rbee_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire in_item_t    item,
  output logic             empty,
  input  wire logic        pop,
  output out_item_t        result,
  input  wire logic        cfg_wr,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [31:0] cfg_data
);

  cfg_t      cfg;
  logic      mid_push;
  mid_item_t mid_in;
  logic      mid_full;
  logic      mid_pop;
  mid_item_t mid_out;
  logic      mid_empty;
  logic      out_push;
  out_item_t out_in;
  logic      out_full;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_freq_step <= STEP_RST;
      cfg.y_freq_step <= STEP_RST;
      cfg.z_freq_step <= STEP_RST;
      cfg.low_cutoff  <= LOW_RST;
      cfg.high_cutoff <= HIGH_RST;
      cfg.linear_coef <= '0;
      cfg.quad_coef   <= '0;
    end else if (cfg_wr) begin
      case (reg_idx_t'(cfg_addr))
        REG_X_STEP: cfg.x_freq_step <= cfg_data[23:0];
        REG_Y_STEP: cfg.y_freq_step <= cfg_data[23:0];
        REG_Z_STEP: cfg.z_freq_step <= cfg_data[23:0];
        REG_LOW:    cfg.low_cutoff  <= cfg_data[23:0];
        REG_HIGH:   cfg.high_cutoff <= cfg_data[23:0];
        REG_LINEAR: cfg.linear_coef <= cfg_data;
        REG_QUAD:   cfg.quad_coef   <= cfg_data;
        default: ;
      endcase
    end
  end

  rbee_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .push     (push),
    .full     (full),
    .item     (item),
    .mid_push (mid_push),
    .mid_item (mid_in),
    .mid_full (mid_full)
  );

  rbee_fifo #(
    .item_t (mid_item_t),
    .DEPTH  (DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .din   (mid_in),
    .full  (mid_full),
    .pop   (mid_pop),
    .dout  (mid_out),
    .empty (mid_empty)
  );

  rbee_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .mid_item  (mid_out),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_item  (out_in)
  );

  rbee_fifo #(
    .item_t (out_item_t),
    .DEPTH  (DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .din   (out_in),
    .full  (out_full),
    .pop   (pop),
    .dout  (result),
    .empty (empty)
  );

endmodule

`default_nettype wire

### rtl/rbee_fifo.sv
// Small register queue with push/full and pop/empty sides.
// Depends on nothing but its parameters.
`default_nettype none

module rbee_fifo #(
  parameter type item_t = logic,
  parameter int  DEPTH  = 2
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t din,
  output logic       full,
  input  wire logic  pop,
  output item_t      dout,
  output logic       empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem [DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rp];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_pop) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store pushed item
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= din;
    end
  end

endmodule

`default_nettype wire

### rtl/rbee_front.sv
// Front part: scales indices, forms the squared radius, picks the band and
// takes the square root in a bit-per-stage pipeline. Uses rbee_pkg.
`default_nettype none

module rbee_front import rbee_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cfg_t      cfg,
  input  wire logic      push,
  output logic           full,
  input  wire in_item_t  item,
  output logic           mid_push,
  output mid_item_t      mid_item,
  input  wire logic      mid_full
);

  localparam int SQRT_STEPS = 24;

  typedef struct packed {
    logic        [31:0] vx;
    logic        [31:0] vy;
    logic        [31:0] vz;
    logic signed [31:0] re;
    logic signed [31:0] im;
  } f1_t;

  typedef struct packed {
    logic        [39:0] sx;
    logic        [39:0] sy;
    logic        [39:0] sz;
    logic signed [31:0] re;
    logic signed [31:0] im;
  } f2_t;

  typedef struct packed {
    logic        [41:0] rsq;
    logic signed [31:0] re;
    logic signed [31:0] im;
  } f3_t;

  typedef struct packed {
    logic        [25:0] rem;
    logic        [23:0] root;
    logic        [47:0] rad;
    logic        [1:0]  band;
    logic        [23:0] rsel;
    logic        [23:0] rr;
    logic signed [31:0] re;
    logic signed [31:0] im;
  } sq_t;

  f1_t                 s1;
  f1_t                 s1_next;
  f2_t                 s2;
  f2_t                 s2_next;
  f3_t                 s3;
  f3_t                 s3_next;
  sq_t                 sq [SQRT_STEPS+1];
  sq_t                 sq0_next;
  logic                v1;
  logic                v2;
  logic                v3;
  logic [SQRT_STEPS:0] vq;
  logic                adv;
  logic [7:0]          mag_y;
  logic [7:0]          mag_z;
  logic [63:0]         px;
  logic [63:0]         py;
  logic [63:0]         pz;
  logic [47:0]         lsq;
  logic [47:0]         hsq;
  logic [23:0]         l2;
  logic [23:0]         h2;

  // Stall the whole front while its last item cannot enter the queue
  assign adv      = !(vq[SQRT_STEPS] && mid_full);
  assign full     = !adv;
  assign mid_push = vq[SQRT_STEPS] && !mid_full;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vq <= '0;
    end else if (adv) begin
      v1 <= push;
      v2 <= v1;
      v3 <= v2;
      vq <= {vq[SQRT_STEPS-1:0], v3};
    end
  end

  // Scale indices by the axis steps
  assign mag_y = item.idx_y[7] ? 8'(-item.idx_y) : 8'(item.idx_y);
  assign mag_z = item.idx_z[7] ? 8'(-item.idx_z) : 8'(item.idx_z);

  always_comb begin
    s1_next.vx = 32'(cfg.x_freq_step) * 32'(item.idx_x);
    s1_next.vy = 32'(cfg.y_freq_step) * 32'(mag_y);
    s1_next.vz = 32'(cfg.z_freq_step) * 32'(mag_z);
    s1_next.re = item.re_in;
    s1_next.im = item.im_in;
  end

  // Square each axis term
  assign px = 64'(s1.vx) * 64'(s1.vx);
  assign py = 64'(s1.vy) * 64'(s1.vy);
  assign pz = 64'(s1.vz) * 64'(s1.vz);

  always_comb begin
    s2_next.sx = px[63:24];
    s2_next.sy = py[63:24];
    s2_next.sz = pz[63:24];
    s2_next.re = s1.re;
    s2_next.im = s1.im;
  end

  // Sum the squared radius
  always_comb begin
    s3_next.rsq = 42'(s2.sx) + 42'(s2.sy) + 42'(s2.sz);
    s3_next.re  = s2.re;
    s3_next.im  = s2.im;
  end

  // Hold squared cutoffs
  assign lsq = 48'(cfg.low_cutoff) * 48'(cfg.low_cutoff);
  assign hsq = 48'(cfg.high_cutoff) * 48'(cfg.high_cutoff);

  always_ff @(posedge clk) begin
    l2 <= lsq[47:24];
    h2 <= hsq[47:24];
  end

  // Classify against the cutoffs and seed the root
  always_comb begin
    sq0_next.rem  = '0;
    sq0_next.root = '0;
    sq0_next.rad  = {s3.rsq[23:0], 24'd0};
    sq0_next.re   = s3.re;
    sq0_next.im   = s3.im;
    if (s3.rsq < 42'(l2)) begin
      sq0_next.band = BAND_BELOW;
      sq0_next.rsel = cfg.low_cutoff;
      sq0_next.rr   = l2;
    end else if (s3.rsq < 42'(h2)) begin
      sq0_next.band = BAND_INSIDE;
      sq0_next.rsel = '0;
      sq0_next.rr   = s3.rsq[23:0];
    end else begin
      sq0_next.band = BAND_ABOVE;
      sq0_next.rsel = cfg.high_cutoff;
      sq0_next.rr   = h2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1    <= s1_next;
      s2    <= s2_next;
      s3    <= s3_next;
      sq[0] <= sq0_next;
    end
  end

  // One root bit per stage
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    logic [27:0] cur;
    logic [27:0] trial;
    logic        ge;
    logic [27:0] diff;
    sq_t         nxt;

    assign cur   = {sq[j].rem, sq[j].rad[47:46]};
    assign trial = {2'b00, sq[j].root, 2'b01};
    assign ge    = (cur >= trial);
    assign diff  = cur - trial;

    always_comb begin
      nxt      = sq[j];
      nxt.rem  = ge ? diff[25:0] : cur[25:0];
      nxt.root = {sq[j].root[22:0], ge};
      nxt.rad  = {sq[j].rad[45:0], 2'b00};
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq[j+1] <= nxt;
      end
    end
  end

  // Pick the radius used in the exponent
  always_comb begin
    mid_item.re   = sq[SQRT_STEPS].re;
    mid_item.im   = sq[SQRT_STEPS].im;
    mid_item.band = sq[SQRT_STEPS].band;
    mid_item.rr   = sq[SQRT_STEPS].rr;
    mid_item.r    = (sq[SQRT_STEPS].band == BAND_INSIDE) ? sq[SQRT_STEPS].root
                                                         : sq[SQRT_STEPS].rsel;
  end

endmodule

`default_nettype wire

### rtl/rbee_back.sv
// Back part: forms the exponent, evaluates the exp gain through a pipelined
// Horner series and scales both parts with saturation. Uses rbee_pkg.
`default_nettype none

module rbee_back import rbee_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cfg_t      cfg,
  input  wire logic      mid_empty,
  output logic           mid_pop,
  input  wire mid_item_t mid_item,
  input  wire logic      out_full,
  output logic           out_push,
  output out_item_t      out_item
);

  localparam int HS = 3 * HORNER_TERMS;
  localparam int NB = 4 + HS + 3;
  localparam logic signed [56:0] E_HI = 57'sd11 <<< 40;
  localparam logic signed [56:0] E_LO = -(57'sd12 <<< 40);

  typedef struct packed {
    logic signed [56:0] pa;
    logic signed [56:0] pb;
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic        [1:0]  band;
  } b1_t;

  typedef struct packed {
    logic signed [29:0] e24;
    logic               big;
    logic               tiny;
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic        [1:0]  band;
  } b2_t;

  typedef struct packed {
    logic signed [60:0] m;
    logic               big;
    logic               tiny;
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic        [1:0]  band;
  } b3_t;

  typedef struct packed {
    logic        [29:0] y;
    logic        [31:0] p;
    logic        [61:0] qm;
    logic        [31:0] q;
    logic        [64:0] em;
    logic signed [5:0]  n;
    logic               big;
    logic               tiny;
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic        [1:0]  band;
  } hs_t;

  typedef struct packed {
    logic        [30:0] gain;
    logic               gsat;
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic        [1:0]  band;
  } gs_t;

  typedef struct packed {
    logic signed [63:0] pre;
    logic signed [63:0] pim;
    logic               gsat;
    logic        [1:0]  band;
  } ps_t;

  b1_t                b1;
  b1_t                b1_next;
  b2_t                b2;
  b2_t                b2_next;
  b3_t                b3;
  b3_t                b3_next;
  hs_t                hp [HS+1];
  hs_t                hp0_next;
  gs_t                gs;
  gs_t                gs_next;
  ps_t                ps;
  ps_t                ps_next;
  out_item_t          res_next;
  logic [NB-1:0]      vb;
  logic               adv;
  logic signed [56:0] e40;
  logic signed [29:0] t;
  logic        [53:0] yp;
  logic signed [6:0]  d;
  logic        [6:0]  nd;
  logic        [63:0] pe;
  logic        [63:0] g;
  logic signed [47:0] qr;
  logic signed [47:0] qi;

  // Stall the whole back while its result cannot enter the output queue
  assign adv      = !(vb[NB-1] && out_full);
  assign out_push = vb[NB-1] && !out_full;
  assign mid_pop  = !mid_empty && adv;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= '0;
    end else if (adv) begin
      vb <= {vb[NB-2:0], !mid_empty};
    end
  end

  // Multiply coefficients by radius terms
  always_comb begin
    b1_next.pa   = $signed(cfg.linear_coef) * $signed({1'b0, mid_item.r});
    b1_next.pb   = $signed(cfg.quad_coef) * $signed({1'b0, mid_item.rr});
    b1_next.re   = mid_item.re;
    b1_next.im   = mid_item.im;
    b1_next.band = mid_item.band;
  end

  // Add the exponent and check the clip limits
  assign e40 = b1.pa + b1.pb;

  always_comb begin
    b2_next.e24  = e40[45:16];
    b2_next.big  = (e40 >= E_HI);
    b2_next.tiny = (e40 <= E_LO);
    b2_next.re   = b1.re;
    b2_next.im   = b1.im;
    b2_next.band = b1.band;
  end

  // Convert to base two
  always_comb begin
    b3_next.m    = $signed(b2.e24) * $signed({1'b0, LOG2E_Q30});
    b3_next.big  = b2.big;
    b3_next.tiny = b2.tiny;
    b3_next.re   = b2.re;
    b3_next.im   = b2.im;
    b3_next.band = b2.band;
  end

  // Split integer and fraction, scale fraction by ln2
  assign t  = b3.m[59:30];
  assign yp = 54'(t[23:0]) * 54'(LN2_Q30);

  always_comb begin
    hp0_next      = '0;
    hp0_next.y    = yp[53:24];
    hp0_next.p    = Q30_ONE;
    hp0_next.n    = t[29:24];
    hp0_next.big  = b3.big;
    hp0_next.tiny = b3.tiny;
    hp0_next.re   = b3.re;
    hp0_next.im   = b3.im;
    hp0_next.band = b3.band;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1    <= b1_next;
      b2    <= b2_next;
      b3    <= b3_next;
      hp[0] <= hp0_next;
    end
  end

  // Horner series, three stages per term: multiply, reciprocal, correct
  for (genvar i = 0; i < HORNER_TERMS; i++) begin : g_horner
    localparam int unsigned  K = HORNER_TERMS - i;
    localparam logic [32:0]  M = recip_q32(K);
    hs_t         na;
    hs_t         nb;
    hs_t         nc;
    logic [31:0] est;
    logic [35:0] rem;

    always_comb begin
      na    = hp[3*i];
      na.qm = 62'(hp[3*i].y) * 62'(hp[3*i].p);
    end

    always_comb begin
      nb    = hp[3*i+1];
      nb.q  = hp[3*i+1].qm[61:30];
      nb.em = 65'(hp[3*i+1].qm[61:30]) * 65'(M);
    end

    assign est = hp[3*i+2].em[63:32];
    assign rem = 36'(hp[3*i+2].q) - 36'(est) * 36'(K);

    always_comb begin
      nc   = hp[3*i+2];
      nc.p = (rem >= 36'(K)) ? Q30_ONE + est + 32'd1 : Q30_ONE + est;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        hp[3*i+1] <= na;
        hp[3*i+2] <= nb;
        hp[3*i+3] <= nc;
      end
    end
  end

  // Shift by the integer part and clip the gain
  assign d  = 7'sd14 - {hp[HS].n[5], hp[HS].n};
  assign nd = 7'(-d);
  assign pe = 64'(hp[HS].p);
  assign g  = (d <= 7'sd0) ? (pe << nd[5:0]) : (pe >> d[5:0]);

  always_comb begin
    gs_next.re   = hp[HS].re;
    gs_next.im   = hp[HS].im;
    gs_next.band = hp[HS].band;
    if (hp[HS].big) begin
      gs_next.gain = GAIN_MAX;
      gs_next.gsat = 1'b1;
    end else if (hp[HS].tiny) begin
      gs_next.gain = '0;
      gs_next.gsat = 1'b0;
    end else if (g > 64'(GAIN_MAX)) begin
      gs_next.gain = GAIN_MAX;
      gs_next.gsat = 1'b1;
    end else begin
      gs_next.gain = g[30:0];
      gs_next.gsat = 1'b0;
    end
  end

  // Multiply both parts by the gain
  always_comb begin
    ps_next.pre  = gs.re * $signed({1'b0, gs.gain});
    ps_next.pim  = gs.im * $signed({1'b0, gs.gain});
    ps_next.gsat = gs.gsat;
    ps_next.band = gs.band;
  end

  // Drop the fraction bits and saturate
  assign qr = ps.pre[63:16];
  assign qi = ps.pim[63:16];

  always_comb begin
    res_next.band      = ps.band;
    res_next.saturated = ps.gsat;
    if (qr > 48'sd2147483647) begin
      res_next.re_out    = 32'sh7FFFFFFF;
      res_next.saturated = 1'b1;
    end else if (qr < -48'sd2147483648) begin
      res_next.re_out    = 32'sh80000000;
      res_next.saturated = 1'b1;
    end else begin
      res_next.re_out = qr[31:0];
    end
    if (qi > 48'sd2147483647) begin
      res_next.im_out    = 32'sh7FFFFFFF;
      res_next.saturated = 1'b1;
    end else if (qi < -48'sd2147483648) begin
      res_next.im_out    = 32'sh80000000;
      res_next.saturated = 1'b1;
    end else begin
      res_next.im_out = qi[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gs       <= gs_next;
      ps       <= ps_next;
      out_item <= res_next;
    end
  end

endmodule

`default_nettype wire

### tb/radial_band_exp_emphasis_tb.sv
// Self-checking testbench of radial_band_exp_emphasis: random and directed
// coefficients through several register settings, compared against a predictor.
// Depends on rbee_pkg and the radial_band_exp_emphasis RTL.
`default_nettype none

module radial_band_exp_emphasis_tb;
  import rbee_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  in_item_t    item;
  logic        empty;
  logic        pop;
  out_item_t   result;
  logic        cfg_wr;
  logic [2:0]  cfg_addr;
  logic [31:0] cfg_data;

  radial_band_exp_emphasis dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_wr(cfg_wr), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  // Predictor copy of the registers
  bit [63:0] x_step, y_step, z_step, low_cut, high_cut;
  longint    lin_coef, quad_coef;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int        errors;
  int        cycles;
  int        results_seen;
  int        send_idle_pct;
  int        recv_stall_pct;
  bit        recv_hold;
  bit        in_taken;

  // Scale one coefficient by exp(A*r + B*r^2) as the block should
  function automatic out_item_t emphasize(in_item_t it);
    bit [63:0] vx, vy, vz, rsq, l2, h2, r, rr, f, y, p, g, bitv, res, v;
    longint    e40, e24, t, n, q, part;
    int        ay, az, k, j;
    bit        sat;
    logic [1:0] bnd;
    out_item_t o;
    ay = it.idx_y < 0 ? -int'(it.idx_y) : int'(it.idx_y);
    az = it.idx_z < 0 ? -int'(it.idx_z) : int'(it.idx_z);
    vx = x_step * 64'(it.idx_x);
    vy = y_step * 64'(ay);
    vz = z_step * 64'(az);
    rsq = ((vx * vx) >> 24) + ((vy * vy) >> 24) + ((vz * vz) >> 24);
    l2 = (low_cut * low_cut) >> 24;
    h2 = (high_cut * high_cut) >> 24;
    sat = 0;
    // Pick the band and the radius used in the exponent
    if (rsq < l2) begin
      bnd = BAND_BELOW; r = low_cut; rr = l2;
    end else if (rsq < h2) begin
      bnd = BAND_INSIDE; rr = rsq;
      v = rsq << 24; res = 0; bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv); res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      r = res;
    end else begin
      bnd = BAND_ABOVE; r = high_cut; rr = h2;
    end
    e40 = lin_coef * longint'(r) + quad_coef * longint'(rr);
    // Gain in Q16.16: base-2 split, Taylor series, then shift
    if (e40 >= (64'sd11 <<< 40)) begin
      sat = 1; g = 64'(GAIN_MAX);
    end else if (e40 <= -(64'sd12 <<< 40)) begin
      g = 0;
    end else begin
      e24 = e40 >>> 16;
      t = (e24 * longint'(LOG2E_Q30)) >>> 30;
      n = t >>> 24;
      f = 64'(t) & 64'hFFFFFF;
      y = (f * 64'(LN2_Q30)) >> 24;
      p = 64'(Q30_ONE);
      for (k = 10; k >= 1; k--)
        p = 64'(Q30_ONE) + ((y * p) >> 30) / 64'(k);
      if (n >= 14) g = p << (n - 14);
      else g = p >> (14 - n);
      if (g > 64'(GAIN_MAX)) begin
        sat = 1; g = 64'(GAIN_MAX);
      end
    end
    // Scale both parts and clip to 32 bits
    for (j = 0; j < 2; j++) begin
      part = (j == 0) ? longint'(it.re_in) : longint'(it.im_in);
      q = (part * longint'(g)) >>> 16;
      if (q > 64'sd2147483647) begin
        sat = 1; q = 64'sd2147483647;
      end
      if (q < -64'sd2147483648) begin
        sat = 1; q = -64'sd2147483648;
      end
      if (j == 0) o.re_out = q[31:0];
      else o.im_out = q[31:0];
    end
    o.band = bnd;
    o.saturated = sat;
    return o;
  endfunction

  // Clock
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Sample accepts, register writes and results at the rising edge
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               expected_results.size());
      $display("end of test: mismatches");
      $finish;
    end
    in_taken = !rst && push && !full;
    if (!rst) begin
      if (cfg_wr) begin
        case (reg_idx_t'(cfg_addr))
          REG_X_STEP: x_step   = 64'(cfg_data[23:0]);
          REG_Y_STEP: y_step   = 64'(cfg_data[23:0]);
          REG_Z_STEP: z_step   = 64'(cfg_data[23:0]);
          REG_LOW:    low_cut  = 64'(cfg_data[23:0]);
          REG_HIGH:   high_cut = 64'(cfg_data[23:0]);
          REG_LINEAR: lin_coef = longint'($signed(cfg_data));
          REG_QUAD:   quad_coef = longint'($signed(cfg_data));
          default: ;
        endcase
      end
      if (in_taken) begin
        expected_results.push_back(emphasize(item));
        void'(pending_items.pop_front());
      end
      if (pop && !empty) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected item %h", $time, result);
        end else begin
          out_item_t e;
          e = expected_results.pop_front();
          if (e !== result) begin
            errors++;
            $display("%0t: mismatch exp re=%h im=%h band=%0d sat=%b",
                     $time, e.re_out, e.im_out, e.band, e.saturated);
            $display("%0t:          got re=%h im=%h band=%0d sat=%b",
                     $time, result.re_out, result.im_out, result.band,
                     result.saturated);
          end
        end
      end
    end
  end

  // Drive items at the falling edge; hold an offered item until taken
  always @(negedge clk) begin
    if (rst) begin
      push <= 0;
    end else if (!push || in_taken) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        push <= 1;
        item <= pending_items[0];
      end else begin
        push <= 0;
      end
    end
  end

  // Pop results at the falling edge
  always @(negedge clk) begin
    if (rst || recv_hold) pop <= 0;
    else pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Hold the receiver off for a long stretch at the start of traffic
  initial begin
    recv_hold = 1;
    wait (!rst && pending_items.size() > 0);
    repeat (400) @(posedge clk);
    recv_hold = 0;
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] data);
    @(negedge clk);
    cfg_wr   <= 1;
    cfg_addr <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_wr   <= 0;
  endtask

  task automatic drain();
    wait (pending_items.size() == 0 && expected_results.size() == 0);
    repeat (80) @(posedge clk);
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    it.idx_x = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(128));
    it.idx_y = 8'($urandom);
    it.idx_z = 8'($urandom);
    case ($urandom_range(3))
      0: begin it.re_in = $urandom; it.im_in = $urandom; end
      1: begin
        it.re_in = $signed(32'($urandom_range(2 * 65536))) - 65536;
        it.im_in = $signed(32'($urandom_range(2 * 65536))) - 65536;
      end
      default: begin
        it.re_in = $signed($urandom) >>> $urandom_range(31);
        it.im_in = $signed($urandom) >>> $urandom_range(31);
      end
    endcase
    return it;
  endfunction

  task automatic load_items(int count);
    repeat (count) pending_items.push_back(random_item());
  endtask

  task automatic load_directed();
    in_item_t it;
    int i;
    for (i = 0; i < 12; i++) begin
      it.idx_x = (i % 3 == 0) ? 8'd0 : (i % 3 == 1) ? 8'd128 : 8'd255;
      it.idx_y = (i % 4 == 0) ? 8'sh80 : (i % 4 == 1) ? 8'sh7F : (i % 4 == 2) ? 8'sh00 : 8'shFF;
      it.idx_z = (i % 2 == 0) ? 8'sh80 : 8'sh7F;
      it.re_in = (i % 4 == 0) ? 32'sh7FFFFFFF : (i % 4 == 1) ? 32'sh80000000 :
                 (i % 4 == 2) ? 32'sh0 : 32'shFFFFFFFF;
      it.im_in = (i % 3 == 0) ? 32'sh80000000 : (i % 3 == 1) ? 32'sh7FFFFFFF : 32'sh10000;
      pending_items.push_back(it);
    end
  endtask

  task automatic set_all(logic [23:0] xs, logic [23:0] ys, logic [23:0] zs,
                         logic [23:0] lo, logic [23:0] hi,
                         logic [31:0] a, logic [31:0] b);
    write_reg(REG_X_STEP, 32'(xs));
    write_reg(REG_Y_STEP, 32'(ys));
    write_reg(REG_Z_STEP, 32'(zs));
    write_reg(REG_LOW, 32'(lo));
    write_reg(REG_HIGH, 32'(hi));
    write_reg(REG_LINEAR, a);
    write_reg(REG_QUAD, b);
  endtask

  // Stimulus: phases of register settings and idling patterns
  initial begin
    int ph;
    rst = 1; push = 0; pop = 0; item = '0; in_taken = 0;
    cfg_wr = 0; cfg_addr = '0; cfg_data = '0;
    errors = 0; cycles = 0; results_seen = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    x_step = 64'(STEP_RST); y_step = 64'(STEP_RST); z_step = 64'(STEP_RST);
    low_cut = 64'(LOW_RST); high_cut = 64'(HIGH_RST);
    lin_coef = 0; quad_coef = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    for (ph = 0; ph < 9; ph++) begin
      // Pick this phase's registers
      case (ph)
        0: ;
        1: set_all(24'd65536, 24'd65536, 24'd65536, 24'd1677722, 24'd6710886,
                   -32'sd655360, -32'sd327680);
        2: set_all(24'd16384, 24'd32768, 24'd8192, 24'd838861, 24'd4194304,
                   32'sd1310720, 32'sd524288);
        3: set_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h0,
                   32'sh7FFFFFFF, 32'sh80000000);
        4: set_all(24'h0, 24'h0, 24'h0, 24'h0, 24'h0,
                   32'sh80000000, 32'sh7FFFFFFF);
        5: set_all(24'd100000, 24'd90000, 24'd120000, 24'd3000000, 24'd12000000,
                   32'sd400000, -32'sd900000);
        default: set_all(24'($urandom_range(200000)), 24'($urandom_range(200000)),
                         24'($urandom), 24'($urandom_range(8000000)),
                         24'($urandom), $signed(32'($urandom_range(3000000))) - 1500000,
                         $signed(32'($urandom_range(3000000))) - 1500000);
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      if (ph < 2) load_directed();
      load_items(ph == 0 ? 500 : 130);
      drain();
    end

    $display("covered %0d results over 9 register settings, including the",
             results_seen);
    $display("register extremes, four idling patterns and a long receiver hold");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
rtl/rbee_pkg.sv
rtl/rbee_fifo.sv
rtl/rbee_front.sv
rtl/rbee_back.sv
rtl/radial_band_exp_emphasis.sv
tb/radial_band_exp_emphasis_tb.sv
